>>> rtl/fan_triangulate_face_normal_defines.svh
// assertion macros for the fan triangulation block
`ifndef FAN_TRIANGULATE_FACE_NORMAL_DEFINES_SVH
`define FAN_TRIANGULATE_FACE_NORMAL_DEFINES_SVH

// property that holds at every clock edge out of reset
`define FTFN_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define FTFN_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/ftfn_pkg.sv
// types, codes and constants shared by the fan triangulation block
package ftfn_pkg;

   localparam int MAX_VERTICES_DEF = 4096;
   localparam int CORNER_W = 12;

   localparam logic FUNC_VERTEX = 1'b0;
   localparam logic FUNC_CORNER = 1'b1;

   typedef struct packed {
      logic               func;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [15:0]        corner_index;
      logic               last_corner;
   } req_type;

   typedef struct packed {
      logic [CORNER_W-1:0] corner_a;
      logic [CORNER_W-1:0] corner_b;
      logic [CORNER_W-1:0] corner_c;
      logic signed [15:0]  normal_x;
      logic signed [15:0]  normal_y;
      logic signed [15:0]  normal_z;
      logic                degenerate;
      logic                bad_index;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vertex_type;

   typedef struct packed {
      logic signed [32:0] e1x;
      logic signed [32:0] e1y;
      logic signed [32:0] e1z;
      logic signed [32:0] e2x;
      logic signed [32:0] e2y;
      logic signed [32:0] e2z;
   } edges_type;

   typedef struct packed {
      logic start;
      logic ack;
   } norm_ctrl_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
   } norm_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_GO,
      ST_WAIT
   } top_state_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_MUL,
      NS_MAG,
      NS_SHIFT,
      NS_SQ,
      NS_ROOT,
      NS_DIV,
      NS_DONE
   } norm_state_type;

endpackage

>>> rtl/ftfn_vertex_mem.sv
// vertex memory, one write and one registered read port
module ftfn_vertex_mem #(
   parameter int DEPTH = ftfn_pkg::MAX_VERTICES_DEF,
   parameter int AW    = $clog2(ftfn_pkg::MAX_VERTICES_DEF)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  ftfn_pkg::vertex_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output ftfn_pkg::vertex_type rd_data
);

   ftfn_pkg::vertex_type mem [DEPTH];
   ftfn_pkg::vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ftfn_normal_unit.sv
// cross product, normalising shift, square root and divisions for one triangle
module ftfn_normal_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  ftfn_pkg::norm_ctrl_type ctrl,
   input  ftfn_pkg::edges_type     edges,
   output ftfn_pkg::norm_stat_type stat
);

   ftfn_pkg::norm_state_type state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic [1:0] comp_ff, comp_in;

   ftfn_pkg::edges_type edges_ff;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_ff;
   logic signed [66:0] acc_ff;
   logic signed [66:0] cross_ff [3];
   logic [66:0]        mag_ff [3];
   logic [2:0]         neg_ff;
   logic [61:0]        sum_ff;
   logic [61:0]        rv_ff;
   logic [62:0]        res_ff;
   logic [62:0]        bit_ff;
   logic [32:0]        rem_ff;
   logic [16:0]        quo_ff;
   logic [16:0]        numlo_ff;
   logic signed [15:0] normal_ff [3];
   logic               degen_ff;

   logic [66:0] orv;
   logic        rs8, rs1, ls8, need_shift;
   logic [63:0] root_t;
   logic        root_ge;
   logic [31:0] len;
   logic [29:0] m_sel;
   logic        n_sel;
   logic [47:0] num;
   logic [33:0] div_t, div_d;
   logic        div_ge;
   logic [16:0] q17;
   logic [15:0] q_sat;

   // shift search
   always_comb begin
      orv        = mag_ff[0] | mag_ff[1] | mag_ff[2];
      rs8        = |orv[66:37];
      rs1        = |orv[66:30];
      ls8        = (orv[29:22] == 8'd0);
      need_shift = rs1 || !orv[29];
   end

   // square root step and divide step
   always_comb begin
      root_t  = {1'b0, res_ff} + {1'b0, bit_ff};
      root_ge = {2'b00, rv_ff} >= root_t;
      len     = res_ff[31:0];
      case (comp_ff)
         2'd0:    begin m_sel = mag_ff[0][29:0]; n_sel = neg_ff[0]; end
         2'd1:    begin m_sel = mag_ff[1][29:0]; n_sel = neg_ff[1]; end
         default: begin m_sel = mag_ff[2][29:0]; n_sel = neg_ff[2]; end
      endcase
      num    = {2'b00, m_sel, 16'd0} + {16'd0, len};
      div_t  = {rem_ff, numlo_ff[16]};
      div_d  = {1'b0, len, 1'b0};
      div_ge = div_t >= div_d;
      q17    = {quo_ff[15:0], div_ge};
      if (n_sel) begin
         q_sat = (q17 > 17'd32768) ? 16'h8000 : 16'(17'd0 - q17);
      end else begin
         q_sat = (q17 > 17'd32767) ? 16'h7FFF : q17[15:0];
      end
   end

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ftfn_pkg::NS_MUL) begin
         case (step_ff)
            6'd0:    begin mul_a = edges_ff.e1y; mul_b = edges_ff.e2z; end
            6'd1:    begin mul_a = edges_ff.e1z; mul_b = edges_ff.e2y; end
            6'd2:    begin mul_a = edges_ff.e1z; mul_b = edges_ff.e2x; end
            6'd3:    begin mul_a = edges_ff.e1x; mul_b = edges_ff.e2z; end
            6'd4:    begin mul_a = edges_ff.e1x; mul_b = edges_ff.e2y; end
            6'd5:    begin mul_a = edges_ff.e1y; mul_b = edges_ff.e2x; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ftfn_pkg::NS_SQ) begin
         case (step_ff)
            6'd0:    mul_a = signed'({3'b000, mag_ff[0][29:0]});
            6'd1:    mul_a = signed'({3'b000, mag_ff[1][29:0]});
            6'd2:    mul_a = signed'({3'b000, mag_ff[2][29:0]});
            default: mul_a = '0;
         endcase
         mul_b = mul_a;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      comp_in  = comp_ff;
      unique case (state_ff)
         ftfn_pkg::NS_IDLE: begin
            step_in = '0;
            comp_in = '0;
            if (ctrl.start) state_in = ftfn_pkg::NS_MUL;
         end
         ftfn_pkg::NS_MUL: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd6) begin
               step_in  = '0;
               state_in = ftfn_pkg::NS_MAG;
            end
         end
         ftfn_pkg::NS_MAG: state_in = ftfn_pkg::NS_SHIFT;
         ftfn_pkg::NS_SHIFT: begin
            if (orv == '0) state_in = ftfn_pkg::NS_DONE;
            else if (!need_shift) state_in = ftfn_pkg::NS_SQ;
         end
         ftfn_pkg::NS_SQ: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd3) begin
               step_in  = '0;
               state_in = ftfn_pkg::NS_ROOT;
            end
         end
         ftfn_pkg::NS_ROOT: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd32) begin
               step_in  = '0;
               comp_in  = '0;
               state_in = ftfn_pkg::NS_DIV;
            end
         end
         ftfn_pkg::NS_DIV: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd17) begin
               step_in = '0;
               comp_in = comp_ff + 2'd1;
               if (comp_ff == 2'd2) state_in = ftfn_pkg::NS_DONE;
            end
         end
         ftfn_pkg::NS_DONE: begin
            if (ctrl.ack) state_in = ftfn_pkg::NS_IDLE;
         end
         default: state_in = ftfn_pkg::NS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      stat.done       = (state_ff == ftfn_pkg::NS_DONE);
      stat.normal_x   = normal_ff[0];
      stat.normal_y   = normal_ff[1];
      stat.normal_z   = normal_ff[2];
      stat.degenerate = degen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftfn_pkg::NS_IDLE;
         step_ff  <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         comp_ff  <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      case (state_ff)
         ftfn_pkg::NS_IDLE: begin
            if (ctrl.start) begin
               edges_ff <= edges;
               degen_ff <= 1'b0;
            end
         end
         ftfn_pkg::NS_MUL: begin
            if (step_ff != 6'd0) begin
               if (step_ff[0]) begin
                  acc_ff <= {mul_ff[65], mul_ff};
               end else begin
                  case (step_ff)
                     6'd2:    cross_ff[0] <= acc_ff - {mul_ff[65], mul_ff};
                     6'd4:    cross_ff[1] <= acc_ff - {mul_ff[65], mul_ff};
                     default: cross_ff[2] <= acc_ff - {mul_ff[65], mul_ff};
                  endcase
               end
            end
         end
         ftfn_pkg::NS_MAG: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= cross_ff[i][66];
               mag_ff[i] <= cross_ff[i][66] ? 67'(-cross_ff[i]) : 67'(cross_ff[i]);
            end
         end
         ftfn_pkg::NS_SHIFT: begin
            if (orv == '0) begin
               degen_ff <= 1'b1;
               for (int i = 0; i < 3; i++) normal_ff[i] <= '0;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (rs8)            mag_ff[i] <= mag_ff[i] >> 8;
                  else if (rs1)       mag_ff[i] <= mag_ff[i] >> 1;
                  else if (ls8)       mag_ff[i] <= mag_ff[i] << 8;
                  else if (!orv[29])  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         ftfn_pkg::NS_SQ: begin
            if (step_ff == 6'd0) sum_ff <= '0;
            else sum_ff <= sum_ff + {2'b00, mul_ff[59:0]};
         end
         ftfn_pkg::NS_ROOT: begin
            if (step_ff == 6'd0) begin
               rv_ff  <= sum_ff;
               res_ff <= '0;
               bit_ff <= 63'd1 << 62;
            end else begin
               if (root_ge) begin
                  rv_ff  <= rv_ff - root_t[61:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end
         ftfn_pkg::NS_DIV: begin
            if (step_ff == 6'd0) begin
               rem_ff   <= {2'b00, num[47:17]};
               numlo_ff <= num[16:0];
               quo_ff   <= '0;
            end else begin
               rem_ff   <= div_ge ? 33'(div_t - div_d) : div_t[32:0];
               numlo_ff <= numlo_ff << 1;
               quo_ff   <= q17;
               if (step_ff == 6'd17) begin
                  case (comp_ff)
                     2'd0:    normal_ff[0] <= q_sat;
                     2'd1:    normal_ff[1] <= q_sat;
                     default: normal_ff[2] <= q_sat;
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/fan_triangulate_face_normal.sv
// top level: vertex store, face fan control and result register
//
//  channel  dir  handshake              payload
//  req      in   req_valid / req_stall  req_data (ftfn_pkg::req_type)
//  rsp      out  rsp_valid / rsp_stall  rsp_data (ftfn_pkg::rsp_type)
//
// a vertex request or a corner that gives no triangle leaves the control idle for the next request
// a triangle result follows its request through three reads and a start, the cross product
// steps, the normalising shift, the squares, a square root and three divisions; a zero
// cross product goes from the shift straight to the result
// reset clears the counters and face state; the vertex memory is not cleared
// requests stall during a triangle, and corners also while a result waits unaccepted
`include "fan_triangulate_face_normal_defines.svh"
module fan_triangulate_face_normal #(
   parameter int MAX_VERTICES = ftfn_pkg::MAX_VERTICES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ftfn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ftfn_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   ftfn_pkg::top_state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] apex_ff, prev_ff, tri_a_ff, tri_b_ff, tri_c_ff;
   logic [1:0]    seen_ff;
   logic          aband_ff;
   ftfn_pkg::vertex_type vtx_a_ff, vtx_b_ff;
   logic              rsp_valid_ff;
   ftfn_pkg::rsp_type rsp_ff;

   logic          accept, is_corner, bad, slot_free, start_tri, wr_en;
   logic [16:0]   idx17;
   logic [IW-1:0] vidx, rd_addr;
   ftfn_pkg::vertex_type wr_data, rd_data;
   ftfn_pkg::edges_type  edges;
   ftfn_pkg::norm_ctrl_type ctrl;
   ftfn_pkg::norm_stat_type stat;
   logic [31:0] ca, cb, cc;

   assign req_stall = (state_ff != ftfn_pkg::ST_IDLE) ||
                      (rsp_valid_ff && req_data.func == ftfn_pkg::FUNC_CORNER);
   assign accept    = req_valid && !req_stall;
   assign is_corner = req_data.func == ftfn_pkg::FUNC_CORNER;
   assign idx17     = {1'b0, req_data.corner_index};
   assign bad       = (req_data.corner_index == 16'd0) || (idx17 > 17'(count_ff));
   assign vidx      = IW'(req_data.corner_index - 16'd1);
   assign start_tri = accept && is_corner && !aband_ff && !bad && seen_ff == 2'd2;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign wr_en   = accept && !is_corner && (count_ff < CW'(MAX_VERTICES));
   assign wr_data = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};

   ftfn_vertex_mem #(
      .DEPTH(MAX_VERTICES),
      .AW   (IW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IW-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   ftfn_normal_unit u_norm (
      .clock(clock),
      .reset(reset),
      .ctrl (ctrl),
      .edges(edges),
      .stat (stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ftfn_pkg::ST_IDLE: if (start_tri) state_in = ftfn_pkg::ST_RD_A;
         ftfn_pkg::ST_RD_A: state_in = ftfn_pkg::ST_RD_B;
         ftfn_pkg::ST_RD_B: state_in = ftfn_pkg::ST_RD_C;
         ftfn_pkg::ST_RD_C: state_in = ftfn_pkg::ST_GO;
         ftfn_pkg::ST_GO:   state_in = ftfn_pkg::ST_WAIT;
         ftfn_pkg::ST_WAIT: if (stat.done && slot_free) state_in = ftfn_pkg::ST_IDLE;
         default:           state_in = ftfn_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rd_addr    = tri_a_ff;
      ctrl.start = 1'b0;
      ctrl.ack   = 1'b0;
      unique case (state_ff)
         ftfn_pkg::ST_RD_B: rd_addr = tri_b_ff;
         ftfn_pkg::ST_RD_C: rd_addr = tri_c_ff;
         ftfn_pkg::ST_GO:   ctrl.start = 1'b1;
         ftfn_pkg::ST_WAIT: ctrl.ack = stat.done && slot_free;
         default:           rd_addr = tri_a_ff;
      endcase
      edges.e1x = {vtx_b_ff.x[31], vtx_b_ff.x} - {vtx_a_ff.x[31], vtx_a_ff.x};
      edges.e1y = {vtx_b_ff.y[31], vtx_b_ff.y} - {vtx_a_ff.y[31], vtx_a_ff.y};
      edges.e1z = {vtx_b_ff.z[31], vtx_b_ff.z} - {vtx_a_ff.z[31], vtx_a_ff.z};
      edges.e2x = {rd_data.x[31], rd_data.x} - {vtx_a_ff.x[31], vtx_a_ff.x};
      edges.e2y = {rd_data.y[31], rd_data.y} - {vtx_a_ff.y[31], vtx_a_ff.y};
      edges.e2z = {rd_data.z[31], rd_data.z} - {vtx_a_ff.z[31], vtx_a_ff.z};
      ca = 32'(tri_a_ff);
      cb = 32'(tri_b_ff);
      cc = 32'(tri_c_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftfn_pkg::ST_IDLE;
         count_ff     <= '0;
         apex_ff      <= '0;
         prev_ff      <= '0;
         seen_ff      <= '0;
         aband_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) count_ff <= count_ff + CW'(1);
         if (ctrl.ack || (accept && is_corner && !aband_ff && bad)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && is_corner) begin
            if (req_data.last_corner) begin
               seen_ff  <= '0;
               aband_ff <= 1'b0;
               apex_ff  <= '0;
               prev_ff  <= '0;
            end else if (!aband_ff) begin
               if (bad) begin
                  aband_ff <= 1'b1;
               end else begin
                  case (seen_ff)
                     2'd0: begin
                        apex_ff <= vidx;
                        seen_ff <= 2'd1;
                     end
                     2'd1: begin
                        prev_ff <= vidx;
                        seen_ff <= 2'd2;
                     end
                     default: prev_ff <= vidx;
                  endcase
               end
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (start_tri) begin
         tri_a_ff <= apex_ff;
         tri_b_ff <= prev_ff;
         tri_c_ff <= vidx;
      end
      if (state_ff == ftfn_pkg::ST_RD_B) vtx_a_ff <= rd_data;
      if (state_ff == ftfn_pkg::ST_RD_C) vtx_b_ff <= rd_data;
      if (accept && is_corner && !aband_ff && bad) begin
         rsp_ff <= ftfn_pkg::rsp_type'{bad_index: 1'b1, default: '0};
      end else if (ctrl.ack) begin
         rsp_ff <= ftfn_pkg::rsp_type'{
            corner_a:   ca[11:0],
            corner_b:   cb[11:0],
            corner_c:   cc[11:0],
            normal_x:   stat.normal_x,
            normal_y:   stat.normal_y,
            normal_z:   stat.normal_z,
            degenerate: stat.degenerate,
            bad_index:  1'b0
         };
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FTFN_ASSERT_ALWAYS(a_count_cap, count_ff <= CW'(MAX_VERTICES), "vertex count beyond capacity")
   `FTFN_ASSERT_ALWAYS(a_seen_sat, seen_ff != 2'd3, "corner count past saturation")
   `FTFN_ASSERT_IMPLY(a_bad_zero, rsp_valid_ff && rsp_ff.bad_index, rsp_ff.normal_x == 16'sd0 && rsp_ff.normal_y == 16'sd0 && rsp_ff.normal_z == 16'sd0 && rsp_ff.corner_a == '0 && rsp_ff.degenerate == 1'b0, "bad index result carries data")
   `FTFN_ASSERT_IMPLY(a_degen_zero, rsp_valid_ff && rsp_ff.degenerate, rsp_ff.normal_x == 16'sd0 && rsp_ff.normal_y == 16'sd0 && rsp_ff.normal_z == 16'sd0, "degenerate result with non-zero normal")

endmodule

>>> test/fan_triangulate_face_normal_test.sv
// testbench for the fan triangulation block: queued requests, own normal calculation, result check
module fan_triangulate_face_normal_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = ftfn_pkg::MAX_VERTICES_DEF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   ftfn_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   ftfn_pkg::rsp_type rsp_data;

   ftfn_pkg::req_type pending_reqs[$];
   ftfn_pkg::rsp_type expected_tris[$];
   logic signed [31:0] store_x[CAPACITY];
   logic signed [31:0] store_y[CAPACITY];
   logic signed [31:0] store_z[CAPACITY];
   int unsigned stored_count = 0;
   int unsigned apex = 0, prev = 0, seen = 0;
   bit          abandoned = 0;
   int unsigned gen_count = 0;
   int unsigned accepted = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 0;
   bit          req_taken = 0;
   bit          failed = 0;

   fan_triangulate_face_normal u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic ftfn_pkg::rsp_type triangle_normal(int unsigned a, int unsigned b,
                                                         int unsigned c);
      logic signed [32:0] e1[3];
      logic signed [32:0] e2[3];
      logic signed [67:0] cr[3];
      logic [67:0] mg[3];
      bit          ng[3];
      logic [63:0] s[3];
      logic [63:0] sum, rem, root, bitv, q;
      int          top;
      ftfn_pkg::rsp_type o;
      e1[0] = store_x[b] - store_x[a];
      e1[1] = store_y[b] - store_y[a];
      e1[2] = store_z[b] - store_z[a];
      e2[0] = store_x[c] - store_x[a];
      e2[1] = store_y[c] - store_y[a];
      e2[2] = store_z[c] - store_z[a];
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      o = '0;
      o.corner_a = a[11:0];
      o.corner_b = b[11:0];
      o.corner_c = c[11:0];
      top = 0;
      for (int i = 0; i < 3; i++) begin
         ng[i] = cr[i] < 0;
         mg[i] = ng[i] ? -cr[i] : cr[i];
         for (int k = 67; k >= 0; k--)
            if (mg[i][k] && k + 1 > top) top = k + 1;
      end
      if (top == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      for (int i = 0; i < 3; i++)
         s[i] = (top > 30) ? 64'(mg[i] >> (top - 30)) : 64'(mg[i] << (30 - top));
      sum = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
      rem = sum;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = (s[i] * 64'd65536 + root) / (64'd2 * root);
         if (ng[i]) begin
            if (q > 32768) q = 32768;
            q = 64'h10000 - q;
         end else if (q > 32767) begin
            q = 32767;
         end
         if (i == 0) o.normal_x = q[15:0];
         else if (i == 1) o.normal_y = q[15:0];
         else o.normal_z = q[15:0];
      end
      return o;
   endfunction

   function automatic void predict_request(ftfn_pkg::req_type r);
      ftfn_pkg::rsp_type o;
      int unsigned idx;
      if (r.func == ftfn_pkg::FUNC_VERTEX) begin
         if (stored_count < CAPACITY) begin
            store_x[stored_count] = r.coord_x;
            store_y[stored_count] = r.coord_y;
            store_z[stored_count] = r.coord_z;
            stored_count++;
         end
         return;
      end
      if (!abandoned) begin
         idx = r.corner_index;
         if (idx == 0 || idx > stored_count) begin
            o = '0;
            o.bad_index = 1'b1;
            expected_tris.insert(expected_tris.size(), o);
            abandoned = 1;
         end else if (seen == 0) begin
            apex = idx - 1;
            seen = 1;
         end else if (seen == 1) begin
            prev = idx - 1;
            seen = 2;
         end else begin
            expected_tris.insert(expected_tris.size(), triangle_normal(apex, prev, idx - 1));
            prev = idx - 1;
         end
      end
      if (r.last_corner) begin
         seen = 0;
         abandoned = 0;
         apex = 0;
         prev = 0;
      end
   endfunction

   task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      ftfn_pkg::req_type r;
      r = '0;
      r.func = ftfn_pkg::FUNC_VERTEX;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.corner_index = 16'($urandom);
      r.last_corner = 1'($urandom_range(1));
      pending_reqs.insert(pending_reqs.size(), r);
      if (gen_count < CAPACITY) gen_count++;
   endtask

   task automatic add_corner(int unsigned idx, bit last);
      ftfn_pkg::req_type r;
      r = '0;
      r.func = ftfn_pkg::FUNC_CORNER;
      r.coord_x = $urandom;
      r.coord_y = $urandom;
      r.coord_z = $urandom;
      r.corner_index = idx[15:0];
      r.last_corner = last;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         2: return 32'($signed($urandom_range(200)) - 100);
         default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      endcase
   endfunction

   function automatic int unsigned bad_corner();
      return $urandom_range(1) ? 0 : $urandom_range(65535, gen_count + 1);
   endfunction

   // stimulus and end of run
   initial begin
      int unsigned n;
      add_corner(1, 1);
      add_vertex(32'h0, 32'h0, 32'h0);
      add_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      add_vertex(32'h80000000, 32'h7fffffff, 32'h80000000);
      add_vertex(32'h00010000, 32'h0, 32'h0);
      add_vertex(32'h0, 32'h00010000, 32'h0);
      add_vertex(32'h0, 32'h0, 32'h0);
      add_corner(1, 0); add_corner(4, 0); add_corner(5, 1);
      add_corner(1, 0); add_corner(2, 0); add_corner(3, 0); add_corner(4, 1);
      add_corner(1, 0); add_corner(6, 0); add_corner(4, 1);
      add_corner(1, 0); add_corner(2, 1);
      add_corner(2, 0); add_corner(0, 0); add_corner(3, 0); add_corner(4, 1);
      add_corner(65535, 0); add_corner(7, 1);
      add_corner(1, 0); add_corner(4, 0); add_corner(5, 0);
      while (pending_reqs.size() < 420) begin
         case ($urandom_range(9))
            0, 1, 2: add_vertex(random_coord(), random_coord(), random_coord());
            3: add_corner($urandom_range(1) ? $urandom : bad_corner(), $urandom_range(1));
            default: begin
               if (gen_count < 3) begin
                  add_vertex(random_coord(), random_coord(), random_coord());
               end else begin
                  n = $urandom_range(6, 3);
                  for (int i = 0; i < n; i++)
                     add_corner(($urandom_range(19) == 0) ? bad_corner()
                                : $urandom_range(gen_count, 1), i == n - 1);
               end
            end
         endcase
      end
      add_corner(1, 1);
      add_corner(CAPACITY, 0); add_corner(1, 0); add_corner(CAPACITY - 1, 0);
      add_corner(2, 1);
      add_corner(1, 0); add_corner(2, 0); add_corner(CAPACITY + 1, 1);

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_valid || expected_tris.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && expected_tris.size() == 0)
         $display("fan_triangulate_face_normal verification clean");
      else
         $display("fan_triangulate_face_normal verification failed");
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      int unsigned idle_pct;
      idle_pct = (((accepted / 110) % 4) == 1) ? 62 : (((accepted / 110) % 4) == 3) ? 23 : 0;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall, with one long hold-off
   always @(negedge clock) begin
      int unsigned stall_pct;
      stall_pct = (((accepted / 110) % 4) == 2) ? 62 : (((accepted / 110) % 4) == 3) ? 23 : 0;
      if (!hold_done && accepted >= 200) begin
         hold_done <= 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      end
   end

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         failed = 1;
      end
   endfunction

   // request capture, result check and watchdog
   always @(posedge clock) begin
      ftfn_pkg::rsp_type want;
      bit      progress;
      progress = 0;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_request(req_data);
         accepted <= accepted + 1;
         progress = 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         progress = 1;
         if (expected_tris.size() == 0) begin
            $error("result with no request waiting for one");
            failed = 1;
         end else begin
            want = expected_tris.pop_front();
            compare_field("corner_a", want.corner_a, rsp_data.corner_a);
            compare_field("corner_b", want.corner_b, rsp_data.corner_b);
            compare_field("corner_c", want.corner_c, rsp_data.corner_c);
            compare_field("normal_x", want.normal_x, rsp_data.normal_x);
            compare_field("normal_y", want.normal_y, rsp_data.normal_y);
            compare_field("normal_z", want.normal_z, rsp_data.normal_z);
            compare_field("degenerate", want.degenerate, rsp_data.degenerate);
            compare_field("bad_index", want.bad_index, rsp_data.bad_index);
         end
      end
      if (reset || progress) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("fan_triangulate_face_normal verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end
endmodule
